// ===== rtl/core/rau_pkg.sv =====
package rau_pkg;

    localparam int DefWordBits = 32;

    typedef enum logic [2:0] {
        OP_REDUCE  = 3'd0,
        OP_ADD     = 3'd1,
        OP_SUB     = 3'd2,
        OP_MUL     = 3'd3,
        OP_DIV     = 3'd4,
        OP_POWER   = 3'd5,
        OP_COMPARE = 3'd6,
        OP_TO_INT  = 3'd7
    } t_op;

    // shared unit commands
    typedef enum logic [1:0] {
        UC_DIV = 2'd0,
        UC_MUL = 2'd1
    } t_ucmd;

    typedef struct packed {
        logic  start;
        t_ucmd cmd;
    } t_uctl;

endpackage

// ===== rtl/core/rau_unit.sv =====
// Shared iterative unit: restoring unsigned divide (one quotient bit a cycle)
// or shift-add multiply modulo 2^W (one multiplier bit a cycle).
module rau_unit import rau_pkg::*; #(
    parameter int WORD_BITS = DefWordBits
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_uctl                i_ctl,
    input  logic [WORD_BITS-1:0] i_x,
    input  logic [WORD_BITS-1:0] i_y,
    output logic                 o_done,
    output logic [WORD_BITS-1:0] o_quo,
    output logic [WORD_BITS-1:0] o_rem
);
    localparam int CW = $clog2(WORD_BITS + 1);

    logic                 r_busy;
    t_ucmd                r_cmd;
    logic [CW-1:0]        r_cnt;
    logic [WORD_BITS-1:0] r_q;
    logic [WORD_BITS-1:0] r_r;
    logic [WORD_BITS-1:0] r_d;
    logic [WORD_BITS:0]   w_trial;
    logic [WORD_BITS-1:0] w_sum;

    assign w_trial = {r_r, r_q[WORD_BITS-1]} - {1'b0, r_d};
    assign w_sum   = r_r + (r_q[0] ? r_d : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cmd  <= i_ctl.cmd;
                r_cnt  <= CW'(WORD_BITS);
                r_q    <= (i_ctl.cmd == UC_DIV) ? i_x : i_y;
                r_r    <= '0;
                r_d    <= i_ctl.cmd == UC_DIV ? i_y : i_x;
            end else if (r_busy) begin
                if (r_cmd == UC_DIV) begin
                    if (!w_trial[WORD_BITS]) begin
                        r_r <= w_trial[WORD_BITS-1:0];
                        r_q <= {r_q[WORD_BITS-2:0], 1'b1};
                    end else begin
                        r_r <= {r_r[WORD_BITS-2:0], r_q[WORD_BITS-1]};
                        r_q <= {r_q[WORD_BITS-2:0], 1'b0};
                    end
                end else begin
                    // multiplicand shifts up, multiplier shifts down
                    r_r <= w_sum;
                    r_d <= {r_d[WORD_BITS-2:0], 1'b0};
                    r_q <= {1'b0, r_q[WORD_BITS-1:1]};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // restoring divider leaves a 1-bit-wider partial remainder only transiently
    assign o_quo = (r_cmd == UC_DIV) ? r_q : r_r;
    assign o_rem = r_r;
endmodule

// ===== rtl/core/rational_arithmetic_unit.sv =====
// The time an item takes depends on its data. Each Euclid step and each product
// is one pass of the shared unit; dividing a pair by its gcd chains two divides.
// Throughput: one item at a time; o_in_ready is low from acceptance to output transfer.
// Reset: synchronous active-low i_rst_n clears the sequencer and output valid.
module rational_arithmetic_unit import rau_pkg::*; #(
    parameter int WORD_BITS = DefWordBits
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_in_ready,
    input  logic [2:0]           i_operation,
    input  logic [WORD_BITS-1:0] i_a_num,
    input  logic [WORD_BITS-1:0] i_a_den,
    input  logic [WORD_BITS-1:0] i_b_num,
    input  logic [WORD_BITS-1:0] i_b_den,
    output logic                 o_valid,
    input  logic                 i_out_ready,
    output logic [WORD_BITS-1:0] o_res_num,
    output logic [WORD_BITS-1:0] o_res_den,
    output logic                 o_less,
    output logic                 o_equal,
    output logic                 o_greater,
    output logic                 o_zero_flag,
    output logic                 o_one_flag,
    output logic                 o_integer_flag,
    output logic                 o_error
);
    localparam int W = WORD_BITS;
    localparam logic [W-1:0] One  = W'(1);

    // Sequencer. Reduce (S_RED to S_DIVDW) is a subroutine: reduce r_pn/r_pd, then continue by r_who.
    typedef enum logic [17:0] {
        S_IDLE   = 18'b000000000000000001,
        S_RED    = 18'b000000000000000010, // start gcd: x=|n|, y=|d|
        S_GCD    = 18'b000000000000000100, // issue x % y
        S_GCDW   = 18'b000000000000001000,
        S_DIVN   = 18'b000000000000010000, // issue |n| / g
        S_DIVNW  = 18'b000000000000100000,
        S_DIVDW  = 18'b000000000001000000,
        S_AFTA   = 18'b000000000010000000, // a reduced
        S_AFTB   = 18'b000000000100000000, // b reduced
        S_MUL    = 18'b000000001000000000, // issue product k
        S_MULW   = 18'b000000010000000000,
        S_POW    = 18'b000000100000000000, // power loop control
        S_POWW   = 18'b000001000000000000,
        S_FINAL  = 18'b000010000000000000, // result reduced
        S_TOINT  = 18'b000100000000000000,
        S_TOINTW = 18'b001000000000000000,
        S_DONE   = 18'b010000000000000000,
        S_OUT    = 18'b100000000000000000
    } t_state;

    t_state r_state, n_state;

    t_op          r_op;
    logic [W-1:0] r_an, r_ad, r_bn, r_bd;  // operands, reduced in place
    logic [W-1:0] r_pn, r_pd;              // pair under reduction
    logic [W-1:0] r_x, r_y;                // Euclid registers
    logic [W-1:0] r_p, r_q, r_e;           // products, power exponent
    logic [W-1:0] r_base, r_acc;
    logic [2:0]   r_k;                     // product / power phase
    logic [1:0]   r_who;                   // 0 a, 1 b, 2 result

    t_uctl        w_ctl;
    logic [W-1:0] w_ux, w_uy, w_quo, w_rem;
    logic         w_done;

    rau_unit #(.WORD_BITS(W)) u_unit (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_ctl),
        .i_x    (w_ux),
        .i_y    (w_uy),
        .o_done (w_done),
        .o_quo  (w_quo),
        .o_rem  (w_rem)
    );

    function automatic logic [W-1:0] f_mag(input logic [W-1:0] v);
        return v[W-1] ? W'(-v) : v;
    endfunction

    function automatic logic [W-1:0] f_sgn(input logic [W-1:0] m, input logic s);
        return s ? W'(-m) : m;
    endfunction

    assign o_in_ready = (r_state == S_IDLE);

    // Drive the shared unit from the current state.
    always_comb begin
        w_ctl = '{start: 1'b0, cmd: UC_DIV};
        w_ux  = r_x;
        w_uy  = r_y;
        case (r_state)
            S_GCD: begin
                w_ctl.start = (r_y != '0);
            end
            S_DIVN: begin
                w_ctl.start = 1'b1;
                w_ux = f_mag(r_pn);
                w_uy = r_x;
            end
            S_DIVNW: begin
                w_ctl.start = w_done;
                w_ux = f_mag(r_pd);
                w_uy = r_x;
            end
            S_MUL: begin
                w_ctl = '{start: 1'b1, cmd: UC_MUL};
                case (r_k)
                    3'd0:    begin w_ux = r_an; w_uy = r_bd; end
                    3'd1:    begin w_ux = r_bn; w_uy = r_ad; end
                    3'd2:    begin w_ux = r_ad; w_uy = r_bd; end
                    3'd3:    begin w_ux = r_an; w_uy = r_bn; end
                    3'd4:    begin w_ux = r_ad; w_uy = r_bn; end
                    default: begin w_ux = r_an; w_uy = r_bd; end
                endcase
            end
            S_POW: begin
                w_ctl.cmd = UC_MUL;
                w_ctl.start = (r_e != '0);
                w_ux = r_e[0] ? r_acc : r_base;
                w_uy = r_base;
            end
            S_TOINT: begin
                w_ctl.start = 1'b1;
                w_ux = f_mag(r_an);
                w_uy = f_mag(r_ad);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_op  <= t_op'(i_operation);
                    r_an  <= i_a_num; r_ad <= i_a_den;
                    r_bn  <= i_b_num; r_bd <= i_b_den;
                    r_pn  <= i_a_num; r_pd <= i_a_den;
                    r_who <= 2'd0;
                    r_state <= S_RED;
                end
                S_RED: begin
                    r_x <= f_mag(r_pn);
                    r_y <= f_mag(r_pd);
                    r_state <= S_GCD;
                end
                S_GCD: begin
                    if (r_y != '0) begin
                        r_state <= S_GCDW;
                    end else if (r_x == '0) begin
                        r_state <= S_DONE;   // gcd zero: error
                        o_error <= 1'b1;
                    end else begin
                        r_state <= S_DIVN;
                    end
                end
                S_GCDW: if (w_done) begin
                    r_x <= r_y;
                    r_y <= w_rem;
                    r_state <= S_GCD;
                end
                S_DIVN: r_state <= S_DIVNW;
                S_DIVNW: if (w_done) begin
                    r_pn <= f_sgn(w_quo, r_pn[W-1]);
                    r_state <= S_DIVDW;
                end
                S_DIVDW: if (w_done) begin
                    r_pd <= f_sgn(w_quo, r_pd[W-1]);
                    case (r_who)
                        2'd0:    r_state <= S_AFTA;
                        2'd1:    r_state <= S_AFTB;
                        default: r_state <= S_FINAL;
                    endcase
                end
                S_AFTA: begin
                    r_an <= r_pn; r_ad <= r_pd;
                    if (r_op == OP_REDUCE) begin
                        r_state <= S_FINAL;
                    end else if (r_op == OP_TO_INT) begin
                        if (r_pd == '0) begin
                            o_error <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_TOINT;
                        end
                    end else begin
                        r_pn <= r_bn; r_pd <= r_bd;
                        r_who <= 2'd1;
                        r_state <= S_RED;
                    end
                end
                S_AFTB: begin
                    r_bn <= r_pn; r_bd <= r_pd;
                    r_who <= 2'd2;
                    case (r_op)
                        OP_ADD, OP_SUB, OP_COMPARE: begin
                            r_k <= 3'd0; r_state <= S_MUL;
                        end
                        OP_MUL: begin r_k <= 3'd3; r_state <= S_MUL; end
                        OP_DIV: begin
                            if (r_pn == '0) begin
                                o_error <= 1'b1; r_state <= S_DONE;
                            end else begin
                                r_k <= 3'd5; r_state <= S_MUL;
                            end
                        end
                        default: begin // power
                            if (r_pd != One) begin
                                o_error <= 1'b1; r_state <= S_DONE;
                            end else if (r_pn == '0) begin
                                r_pn <= One; r_pd <= One; r_state <= S_FINAL;
                            end else begin
                                r_e <= f_mag(r_pn); r_base <= r_an;
                                r_acc <= One; r_k <= 3'd0;
                                r_state <= S_POW;
                            end
                        end
                    endcase
                end
                S_MUL: r_state <= S_MULW;
                S_MULW: if (w_done) begin
                    case (r_k)
                        3'd0: begin r_p <= w_quo; r_k <= 3'd1; r_state <= S_MUL; end
                        3'd1: begin
                            if (r_op == OP_COMPARE) begin
                                o_less    <= ($signed(r_p) <  $signed(w_quo));
                                o_equal   <= (r_p == w_quo);
                                o_greater <= ($signed(r_p) >  $signed(w_quo));
                                r_state   <= S_DONE;
                            end else begin
                                r_pn <= (r_op == OP_ADD) ? r_p + w_quo : r_p - w_quo;
                                r_k <= 3'd2; r_state <= S_MUL;
                            end
                        end
                        3'd2: begin r_pd <= w_quo; r_state <= S_RED; end
                        3'd3: begin r_pn <= w_quo; r_k <= 3'd2; r_state <= S_MUL; end
                        3'd4: begin r_pd <= w_quo; r_state <= S_RED; end
                        default: begin r_pn <= w_quo; r_k <= 3'd4; r_state <= S_MUL; end
                    endcase
                end
                // r_k[0]: 0 numerator pass, 1 denominator pass.
                // r_k[1]: 1 when this multiply is the square, 0 the accumulate.
                S_POW: begin
                    if (r_e != '0) begin
                        r_state <= S_POWW;
                        r_k[1]  <= ~r_e[0];
                    end else if (!r_k[0]) begin
                        r_q <= r_acc;              // hold numerator power
                        r_e <= f_mag(r_bn); r_base <= r_ad;
                        r_acc <= One; r_k <= 3'd1;
                    end else begin
                        r_pn <= r_bn[W-1] ? r_acc : r_q;
                        r_pd <= r_bn[W-1] ? r_q : r_acc;
                        r_state <= S_RED;
                    end
                end
                S_POWW: if (w_done) begin
                    if (r_k[1]) begin
                        r_base <= w_quo;
                        r_e <= {1'b0, r_e[W-1:1]};
                    end else begin
                        r_acc <= w_quo;
                        r_e <= {r_e[W-1:1], 1'b0};
                    end
                    r_state <= S_POW;
                end
                S_TOINT: r_state <= S_TOINTW;
                S_TOINTW: if (w_done) begin
                    r_pn <= f_sgn(w_quo, r_an[W-1] ^ r_ad[W-1]);
                    r_pd <= One;
                    r_state <= S_FINAL;
                end
                S_FINAL: begin
                    o_res_num      <= r_pn;
                    o_res_den      <= r_pd;
                    o_zero_flag    <= (r_pn == '0);
                    o_one_flag     <= (r_pn == One) && (r_pd == One);
                    o_integer_flag <= (r_pd == One);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    o_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: if (i_out_ready) begin
                    o_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            // clear the result fields when a new item is taken
            if (r_state == S_IDLE && i_valid) begin
                o_res_num <= '0; o_res_den <= '0;
                o_less <= 1'b0; o_equal <= 1'b0; o_greater <= 1'b0;
                o_zero_flag <= 1'b0; o_one_flag <= 1'b0;
                o_integer_flag <= 1'b0; o_error <= 1'b0;
            end
            // an error wipes any partial result
            if (r_state == S_DONE && o_error) begin
                o_res_num <= '0; o_res_den <= '0;
                o_zero_flag <= 1'b0; o_one_flag <= 1'b0;
                o_integer_flag <= 1'b0;
            end
        end
    end

    // Output held while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_out_ready |=> o_valid && $stable(o_res_num))
        else $error("result changed while stalled");
    // Never ready while a result waits.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_in_ready))
        else $error("ready with pending result");
    // Compare outcomes are mutually exclusive.
    a_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones({o_less, o_equal, o_greater}) <= 1)
        else $error("compare flags overlap");
    // An error result carries no fraction.
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_res_num == '0 && o_res_den == '0)
        else $error("error with nonzero result");
endmodule

// ===== tb/tb_rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps

module tb_rational_arithmetic_unit import rau_pkg::*; ();

    localparam int          WB         = 32;
    localparam logic [31:0] W_MIN      = 32'h8000_0000;
    localparam logic [31:0] W_MAX      = 32'h7fff_ffff;
    localparam int          STALL_LIM  = 60000;
    localparam int          HOLD_LEN   = 400;

    typedef struct {
        t_op         op;
        logic [31:0] an;
        logic [31:0] ad;
        logic [31:0] bn;
        logic [31:0] bd;
    } t_frac_req;

    typedef struct {
        logic [31:0] num;
        logic [31:0] den;
        logic        lt;
        logic        eq;
        logic        gt;
        logic        zero;
        logic        one;
        logic        integ;
        logic        err;
    } t_frac_res;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_valid     = 1'b0;
    logic          o_in_ready;
    logic [2:0]    i_operation = '0;
    logic [WB-1:0] i_a_num     = '0;
    logic [WB-1:0] i_a_den     = '0;
    logic [WB-1:0] i_b_num     = '0;
    logic [WB-1:0] i_b_den     = '0;
    logic          o_valid;
    logic          i_out_ready = 1'b0;
    logic [WB-1:0] o_res_num;
    logic [WB-1:0] o_res_den;
    logic          o_less;
    logic          o_equal;
    logic          o_greater;
    logic          o_zero_flag;
    logic          o_one_flag;
    logic          o_integer_flag;
    logic          o_error;

    t_frac_res pending_results[$];
    int        mismatches  = 0;
    int        items_sent  = 0;
    int        results_seen = 0;
    int        errors_seen = 0;
    int        idle_cycles = 0;
    int        hold_cycles = 0;
    bit        calm        = 1'b0;

    rational_arithmetic_unit #(.WORD_BITS(WB)) u_dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Fraction predictor
    // ---------------------------------------------------------------
    function automatic logic [31:0] magnitude(logic [31:0] v);
        return v[31] ? -v : v;
    endfunction

    function automatic logic [31:0] euclid_gcd(logic [31:0] x, logic [31:0] y);
        logic [31:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Divide each part by the gcd magnitude; each part keeps its own sign.
    function automatic bit reduce_frac(inout logic [31:0] n, inout logic [31:0] d);
        logic [31:0] g;
        logic [31:0] m;
        g = euclid_gcd(magnitude(n), magnitude(d));
        if (g == 0) return 1'b0;
        m = magnitude(n) / g;
        n = n[31] ? -m : m;
        m = magnitude(d) / g;
        d = d[31] ? -m : m;
        return 1'b1;
    endfunction

    function automatic logic [31:0] wrap_power(logic [31:0] base, logic [31:0] e);
        logic [31:0] r;
        r = 1;
        while (e != 0) begin
            if (e[0]) r = r * base;
            base = base * base;
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic t_frac_res predict_frac(t_frac_req rq);
        t_frac_res   r;
        logic [31:0] an, ad, bn, bd, rn, rd, p, q, t;
        bit          ok;
        an = rq.an; ad = rq.ad; bn = rq.bn; bd = rq.bd;
        rn = 0; rd = 0;
        r = '{default: '0};
        ok = reduce_frac(an, ad);
        if (ok && rq.op != OP_REDUCE && rq.op != OP_TO_INT) ok = reduce_frac(bn, bd);
        if (ok) begin
            case (rq.op)
                OP_REDUCE: begin
                    rn = an; rd = ad;
                end
                OP_ADD, OP_SUB: begin
                    p = an * bd;
                    q = bn * ad;
                    rn = (rq.op == OP_ADD) ? p + q : p - q;
                    rd = ad * bd;
                    ok = reduce_frac(rn, rd);
                end
                OP_MUL: begin
                    rn = an * bn; rd = ad * bd;
                    ok = reduce_frac(rn, rd);
                end
                OP_DIV: begin
                    if (bn == 0) ok = 1'b0;
                    else begin
                        rn = an * bd; rd = ad * bn;
                        ok = reduce_frac(rn, rd);
                    end
                end
                OP_POWER: begin
                    if (bd != 1) ok = 1'b0;
                    else if (bn == 0) begin
                        rn = 1; rd = 1;
                    end else begin
                        rn = wrap_power(an, magnitude(bn));
                        rd = wrap_power(ad, magnitude(bn));
                        if (bn[31]) begin
                            t = rn; rn = rd; rd = t;
                        end
                        ok = reduce_frac(rn, rd);
                    end
                end
                OP_COMPARE: begin
                    p = an * bd;
                    q = bn * ad;
                    r.lt = $signed(p) < $signed(q);
                    r.eq = p == q;
                    r.gt = $signed(p) > $signed(q);
                end
                default: begin
                    if (ad == 0) ok = 1'b0;
                    else begin
                        t = magnitude(an) / magnitude(ad);
                        rn = (an[31] ^ ad[31]) ? -t : t;
                        rd = 1;
                    end
                end
            endcase
        end
        if (!ok) begin
            r = '{default: '0};
            r.err = 1'b1;
        end else if (rq.op != OP_COMPARE) begin
            r.num   = rn;
            r.den   = rd;
            r.zero  = rn == 0;
            r.one   = rn == 1 && rd == 1;
            r.integ = rd == 1;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Sender: one transfer per call; valid stays high across back-to-back
    // items and drops only on a gap.
    // ---------------------------------------------------------------
    task automatic send_frac(t_frac_req rq);
        i_valid     <= 1'b1;
        i_operation <= rq.op;
        i_a_num     <= rq.an;
        i_a_den     <= rq.ad;
        i_b_num     <= rq.bn;
        i_b_den     <= rq.bd;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(predict_frac(rq));
        items_sent++;
        if (!calm && $urandom_range(99) < 12) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic send_ops(t_op op, logic [31:0] an, logic [31:0] ad,
                            logic [31:0] bn, logic [31:0] bd);
        t_frac_req rq;
        rq = '{op, an, ad, bn, bd};
        send_frac(rq);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Mostly small values so that gcd and results stay meaningful;
    // the rest covers extremes and full-width patterns.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom_range(40) - 20;
            4, 5:       return $urandom_range(2000) - 1000;
            6:          return $urandom;
            7:          return $urandom_range(65535) - 32768;
            default: begin
                case ($urandom_range(4))
                    0: return W_MIN;
                    1: return W_MAX;
                    2: return 0;
                    3: return 1;
                    default: return 32'hffff_ffff;
                endcase
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_den();
        logic [31:0] v;
        v = pick_word();
        // keep zero denominators rare
        if (v == 0 && $urandom_range(3) != 0) v = $urandom_range(1, 12);
        return v;
    endfunction

    function automatic t_frac_req pick_req();
        t_frac_req rq;
        logic [31:0] k;
        rq.op = t_op'($urandom_range(7));
        rq.an = pick_word();
        rq.ad = pick_den();
        rq.bn = pick_word();
        rq.bd = pick_den();
        if (rq.op == OP_POWER && $urandom_range(9) != 0) begin
            // well-formed exponent: b reduces to an integer over 1 unless the scaled numerator wraps
            k = $urandom_range(1, 6);
            rq.bn = ($urandom_range(7) == 0 ? $urandom : $urandom_range(24) - 12) * k;
            rq.bd = k;
        end
        return rq;
    endfunction

    // ---------------------------------------------------------------
    // Result checker and receiver stalls
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_frac_res want;
        if (i_rst_n && o_valid && i_out_ready) begin
            results_seen++;
            if (o_error) errors_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result num=%h den=%h",
                                               o_res_num, o_res_den);
            end else begin
                want = pending_results.pop_front();
                if (o_res_num !== want.num || o_res_den !== want.den ||
                    o_less !== want.lt || o_equal !== want.eq ||
                    o_greater !== want.gt || o_zero_flag !== want.zero ||
                    o_one_flag !== want.one || o_integer_flag !== want.integ ||
                    o_error !== want.err) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"mismatch exp num=%h den=%h lt=%b eq=%b gt=%b",
                                  " z=%b o=%b i=%b e=%b"},
                                 want.num, want.den, want.lt, want.eq, want.gt,
                                 want.zero, want.one, want.integ, want.err);
                        $display({"         got num=%h den=%h lt=%b eq=%b gt=%b",
                                  " z=%b o=%b i=%b e=%b"},
                                 o_res_num, o_res_den, o_less, o_equal, o_greater,
                                 o_zero_flag, o_one_flag, o_integer_flag, o_error);
                    end
                end
            end
        end
        // hold off output while a long stall is requested, else random idling
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(99) >= 12);
        end
    end

    // Watchdog: count cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if ((i_valid && o_in_ready) || (o_valid && i_out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIM) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed();
        send_ops(OP_REDUCE,  6, -4, 0, 0);
        send_ops(OP_REDUCE,  0, 0, 5, 7);               // zero over zero
        send_ops(OP_REDUCE,  7, 0, 0, 0);               // x over zero reduces to 1/0
        send_ops(OP_REDUCE,  W_MIN, W_MIN, 0, 0);       // gcd reaches 2^31
        send_ops(OP_ADD,     1, 2, 1, 3);
        send_ops(OP_ADD,     W_MAX, 1, W_MAX, 1);
        send_ops(OP_SUB,     1, 2, 1, 2);
        send_ops(OP_SUB,     3, -4, 0, 0);              // b zero over zero
        send_ops(OP_MUL,     W_MIN, 3, -1, 5);
        send_ops(OP_MUL,     2, 3, 3, 2);
        send_ops(OP_DIV,     3, 4, 0, 5);               // divide by zero
        send_ops(OP_DIV,     -3, 4, 9, -8);
        send_ops(OP_POWER,   2, 3, 5, 1);
        send_ops(OP_POWER,   2, 3, -3, 1);
        send_ops(OP_POWER,   5, 7, 0, 1);
        send_ops(OP_POWER,   2, 3, 1, 2);               // bad exponent
        send_ops(OP_POWER,   3, 1, 6, 2);               // exponent reduces to 3/1
        send_ops(OP_POWER,   -1, 1, W_MIN, 1);
        send_ops(OP_COMPARE, 1, 2, 2, 3);
        send_ops(OP_COMPARE, 2, 4, 1, 2);
        send_ops(OP_COMPARE, W_MAX, 1, -1, 1);
        send_ops(OP_TO_INT,  W_MIN, -1, 0, 0);          // quotient wraps to MIN
        send_ops(OP_TO_INT,  -7, 2, 0, 0);
        send_ops(OP_TO_INT,  0, 5, 0, 0);
        drain_results();
    endtask

    task automatic test_random(int count);
        repeat (count) send_frac(pick_req());
    endtask

    task automatic test_no_idle(int count);
        calm = 1'b1;
        test_random(count);
        drain_results();
        calm = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_cycles = HOLD_LEN;
        test_random(20);
    endtask

    task automatic test_drain_pause();
        test_random(30);
        drain_results();
        test_random(30);
    endtask

    task automatic test_power(int count);
        t_frac_req rq;
        repeat (count) begin
            rq = pick_req();
            rq.op = OP_POWER;
            send_frac(rq);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(600);
        test_backpressure();
        test_no_idle(250);
        test_drain_pause();
        test_power(150);
        test_random(650);

        drain_results();
        repeat (50) @(posedge i_clk);
        $display("Covered %0d fraction items over all eight operations, %0d results, %0d errors",
                 items_sent, results_seen, errors_seen);
        $display("including a long output stall, a no-idle stretch and a full drain pause");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("mismatches=%0d left over=%0d", mismatches, pending_results.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
